>>> design/shtp_ry_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shtp_ry_pkg: shared constants and types for the rotation report yaw block
// Framing limits, window geometry, CORDIC angle units and the packet event.
// ----------------------------------------------------------------------------
package shtp_ry_pkg;

   // packet framing
   localparam int MAX_PACKET_LEN = 1024;
   localparam int HEADER_LEN     = 4;
   localparam int LEN_W          = 15;
   localparam int WIN_LEN        = 17;
   localparam int WIN_AW         = $clog2(WIN_LEN);
   localparam int POS_NAT_W      = $clog2(MAX_PACKET_LEN - HEADER_LEN + 1);
   localparam int POS_W          = (POS_NAT_W > WIN_AW) ? POS_NAT_W : WIN_AW;
   localparam logic [7:0] TIMEBASE_MARK = 8'hFB;
   localparam int TIMEBASE_SKIP  = 5;
   localparam int REPORT_MIN_LEN = 12;

   // cordic, angle units with a half turn of 2^19
   localparam int CORDIC_STEPS   = 16;
   localparam int STEP_W         = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int ANG_W          = 21;
   localparam int HALF_TURN_LOG2 = 19;
   localparam int QUARTER_TURN   = 262144;
   localparam int CENTIDEG_HALF  = 18000;

   // configuration register indexes
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPTED_REPORT_ID = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_CHANNEL     = 8'd1;
   localparam logic [7:0] ACCEPTED_REPORT_ID_RESET = 8'd8;
   localparam logic [7:0] REPORT_CHANNEL_RESET     = 8'd3;

   // end of a report packet that passed the channel and length checks
   typedef struct packed {
      logic valid;
      logic timebase;
   } event_type;

   // atan(2^-s) / pi * 2^19, rounded
   function automatic logic signed [ANG_W-1:0] atan_units(input logic [4:0] s);
      logic signed [ANG_W-1:0] v;
      case (s)
         5'd0:    v = 21'sd131072;
         5'd1:    v = 21'sd77376;
         5'd2:    v = 21'sd40884;
         5'd3:    v = 21'sd20753;
         5'd4:    v = 21'sd10417;
         5'd5:    v = 21'sd5213;
         5'd6:    v = 21'sd2607;
         5'd7:    v = 21'sd1304;
         5'd8:    v = 21'sd652;
         5'd9:    v = 21'sd326;
         5'd10:   v = 21'sd163;
         5'd11:   v = 21'sd81;
         5'd12:   v = 21'sd41;
         5'd13:   v = 21'sd20;
         5'd14:   v = 21'sd10;
         5'd15:   v = 21'sd5;
         5'd16:   v = 21'sd3;
         5'd17:   v = 21'sd1;
         5'd18:   v = 21'sd1;
         default: v = 21'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> design/shtp_ry_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shtp_ry_framer: packet framer and payload window
// Parses the 4-byte header, counts payload bytes, keeps the first bytes in a
// small memory and flags the end of a report packet on the report channel.
// ----------------------------------------------------------------------------
module shtp_ry_framer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            byte_take,
   input  wire logic [7:0]                      rx_byte,
   input  wire logic [7:0]                      report_channel,
   input  wire logic [shtp_ry_pkg::WIN_AW-1:0]  rd_addr,
   output logic [7:0]                           rd_data,
   output shtp_ry_pkg::event_type               evt
);

   localparam logic [2:0] HDR_LEN_LO  = 3'd0;
   localparam logic [2:0] HDR_LEN_HI  = 3'd1;
   localparam logic [2:0] HDR_CHANNEL = 3'd2;
   localparam logic [2:0] HDR_SEQ     = 3'd3;
   localparam logic [2:0] HDR_DONE    = 3'd4;

   logic [2:0]                          header_count_ff, header_count_in;
   logic [shtp_ry_pkg::LEN_W-1:0]       packet_length_ff, packet_length_in;
   logic [7:0]                          packet_channel_ff, packet_channel_in;
   logic [shtp_ry_pkg::POS_W-1:0]       payload_position_ff, payload_position_in;
   logic                                mark_ff, mark_in;
   logic [7:0]                          rd_data_ff;
   logic [7:0]                          window_mem [shtp_ry_pkg::WIN_LEN];

   logic                                win_write;
   logic [shtp_ry_pkg::LEN_W-1:0]       body_len;
   logic [shtp_ry_pkg::LEN_W-1:0]       pos_next_wide;
   logic                                mark_now;
   logic [shtp_ry_pkg::LEN_W-1:0]       need_len;

   assign body_len      = packet_length_ff - shtp_ry_pkg::LEN_W'(shtp_ry_pkg::HEADER_LEN);
   assign pos_next_wide = shtp_ry_pkg::LEN_W'(payload_position_ff) + 15'd1;
   assign mark_now      = (payload_position_ff == '0) ? (rx_byte == shtp_ry_pkg::TIMEBASE_MARK)
                                                      : mark_ff;
   assign need_len      = mark_now
      ? shtp_ry_pkg::LEN_W'(shtp_ry_pkg::TIMEBASE_SKIP + shtp_ry_pkg::REPORT_MIN_LEN)
      : shtp_ry_pkg::LEN_W'(shtp_ry_pkg::REPORT_MIN_LEN);

   // header and payload bookkeeping
   always_comb begin
      header_count_in     = header_count_ff;
      packet_length_in    = packet_length_ff;
      packet_channel_in   = packet_channel_ff;
      payload_position_in = payload_position_ff;
      mark_in             = mark_ff;
      win_write           = 1'b0;
      evt                 = '0;
      if (byte_take) begin
         if (header_count_ff != HDR_DONE) begin
            case (header_count_ff)
               HDR_LEN_LO:  packet_length_in = {7'd0, rx_byte};
               HDR_LEN_HI:  packet_length_in = {rx_byte[6:0], packet_length_ff[7:0]};
               HDR_CHANNEL: packet_channel_in = rx_byte;
               default:     packet_length_in = packet_length_ff;
            endcase
            header_count_in = header_count_ff + 3'd1;
            if (header_count_ff == HDR_SEQ) begin
               payload_position_in = '0;
               // header-only packet on an empty or bad length
               if (packet_length_ff <= shtp_ry_pkg::LEN_W'(shtp_ry_pkg::HEADER_LEN) ||
                   packet_length_ff > shtp_ry_pkg::LEN_W'(shtp_ry_pkg::MAX_PACKET_LEN)) begin
                  header_count_in = HDR_LEN_LO;
               end
            end
         end else begin
            win_write           = (payload_position_ff < shtp_ry_pkg::POS_W'(shtp_ry_pkg::WIN_LEN));
            mark_in             = mark_now;
            payload_position_in = payload_position_ff + 1'b1;
            if (pos_next_wide >= body_len) begin
               header_count_in = HDR_LEN_LO;
               evt.valid    = (packet_channel_ff == report_channel) && (need_len <= body_len);
               evt.timebase = mark_now;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff     <= HDR_LEN_LO;
         packet_length_ff    <= '0;
         packet_channel_ff   <= '0;
         payload_position_ff <= '0;
         mark_ff             <= 1'b0;
      end else begin
         header_count_ff     <= header_count_in;
         packet_length_ff    <= packet_length_in;
         packet_channel_ff   <= packet_channel_in;
         payload_position_ff <= payload_position_in;
         mark_ff             <= mark_in;
      end
   end

   // payload window, one write and one registered read
   always_ff @(posedge clock) begin
      if (win_write) begin
         window_mem[payload_position_ff[shtp_ry_pkg::WIN_AW-1:0]] <= rx_byte;
      end
      rd_data_ff <= window_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/shtp_ry_solver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shtp_ry_solver: report check, quaternion products, CORDIC and scaling
// A sequencer reads the report from the window, runs one shared multiplier
// for the products and the degree scale, iterates a shift-add CORDIC unit
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module shtp_ry_solver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire shtp_ry_pkg::event_type          evt,
   input  wire logic [7:0]                      accepted_report_id,
   input  wire logic [7:0]                      rd_data,
   output logic [shtp_ry_pkg::WIN_AW-1:0]       rd_addr,
   output logic                                 busy,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic signed [15:0]                   rsp_yaw_centideg,
   output logic                                 rsp_timebase_present
);

   localparam int AW = shtp_ry_pkg::ANG_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_LOAD  = 4'd3;
   localparam logic [3:0] S_PRE   = 4'd4;
   localparam logic [3:0] S_ITER  = 4'd5;
   localparam logic [3:0] S_ABS   = 4'd6;
   localparam logic [3:0] S_SCALE = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   localparam logic [3:0] RD_ID   = 4'd1;
   localparam logic [3:0] RD_LAST = 4'd9;
   localparam logic [2:0] MUL_LAST = 3'd4;

   localparam logic [shtp_ry_pkg::STEP_W-1:0] STEP_LAST =
      shtp_ry_pkg::STEP_W'(shtp_ry_pkg::CORDIC_STEPS - 1);
   localparam logic signed [33:0] X_BIAS = 34'sd134217728;
   localparam logic signed [AW-1:0] QTURN = AW'(shtp_ry_pkg::QUARTER_TURN);

   logic [3:0]                        state_ff, state_in;
   logic [3:0]                        rd_cnt_ff, rd_cnt_in;
   logic [2:0]                        mul_cnt_ff, mul_cnt_in;
   logic [shtp_ry_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                              timebase_ff, timebase_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic [63:0]                       q_ff, q_in;
   logic signed [37:0]                prod_ff;
   logic signed [33:0]                acc_y_ff, acc_y_in, acc_x_ff, acc_x_in;
   logic signed [31:0]                x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0]              ang_ff, ang_in;
   logic [19:0]                       mag_ff, mag_in;
   logic                              neg_ff, neg_in;
   logic signed [15:0]                yaw_ff, yaw_in;
   logic                              tb_out_ff, tb_out_in;

   logic signed [15:0]                qi, qj, qk, qr;
   logic signed [20:0]                mul_a;
   logic signed [16:0]                mul_b;
   logic [shtp_ry_pkg::WIN_AW-1:0]    base_addr;
   logic signed [31:0]                x_sh, y_sh;
   logic signed [AW-1:0]              atan_val, ang_neg;
   logic [37:0]                       rounded;
   logic [18:0]                       cd_raw;
   logic [15:0]                       cd16;

   // truncating divide by four
   function automatic logic signed [31:0] div4_trunc(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = v[33] ? (v + 34'sd3) : v;
      return t[33:2];
   endfunction

   assign qi = q_ff[15:0];
   assign qj = q_ff[31:16];
   assign qk = q_ff[47:32];
   assign qr = q_ff[63:48];

   // window read address: report id first, then the quaternion bytes
   assign base_addr = timebase_ff ? shtp_ry_pkg::WIN_AW'(shtp_ry_pkg::TIMEBASE_SKIP) : '0;
   assign rd_addr   = (rd_cnt_ff == '0) ? base_addr
                                        : base_addr + 5'd3 + shtp_ry_pkg::WIN_AW'(rd_cnt_ff);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_MUL) begin
         case (mul_cnt_ff)
            3'd0:    begin mul_a = {{5{qr[15]}}, qr}; mul_b = {qk[15], qk}; end
            3'd1:    begin mul_a = {{5{qi[15]}}, qi}; mul_b = {qj[15], qj}; end
            3'd2:    begin mul_a = {{5{qj[15]}}, qj}; mul_b = {qj[15], qj}; end
            default: begin mul_a = {{5{qk[15]}}, qk}; mul_b = {qk[15], qk}; end
         endcase
      end else if (state_ff == S_SCALE) begin
         mul_a = {1'b0, mag_ff};
         mul_b = 17'(shtp_ry_pkg::CENTIDEG_HALF);
      end
   end

   // cordic shift-add unit
   assign x_sh     = x_ff >>> step_ff;
   assign y_sh     = y_ff >>> step_ff;
   assign atan_val = shtp_ry_pkg::atan_units(5'(step_ff));
   assign ang_neg  = -ang_ff;

   // rounding and clamp to hundredths of a degree
   assign rounded = prod_ff + 38'sd262144;
   assign cd_raw  = rounded[37:shtp_ry_pkg::HALF_TURN_LOG2];
   assign cd16    = (cd_raw > 19'(shtp_ry_pkg::CENTIDEG_HALF))
                  ? 16'(shtp_ry_pkg::CENTIDEG_HALF) : cd_raw[15:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      mul_cnt_in   = mul_cnt_ff;
      step_in      = step_ff;
      timebase_in  = timebase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_in         = q_ff;
      acc_y_in     = acc_y_ff;
      acc_x_in     = acc_x_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ang_in       = ang_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      yaw_in       = yaw_ff;
      tb_out_in    = tb_out_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (evt.valid) begin
               state_in    = S_READ;
               rd_cnt_in   = '0;
               timebase_in = evt.timebase;
            end
         end
         S_READ: begin
            rd_cnt_in = rd_cnt_ff + 4'd1;
            if (rd_cnt_ff == RD_ID && rd_data != accepted_report_id) begin
               state_in = S_IDLE;
            end else if (rd_cnt_ff > RD_ID) begin
               q_in = {rd_data, q_ff[63:8]};
            end
            if (rd_cnt_ff == RD_LAST) begin
               state_in   = S_MUL;
               mul_cnt_in = '0;
            end
         end
         S_MUL: begin
            mul_cnt_in = mul_cnt_ff + 3'd1;
            case (mul_cnt_ff)
               3'd1:    acc_y_in = prod_ff[33:0];
               3'd2:    acc_y_in = acc_y_ff + prod_ff[33:0];
               3'd3:    acc_x_in = X_BIAS - prod_ff[33:0];
               3'd4:    acc_x_in = acc_x_ff - prod_ff[33:0];
               default: acc_y_in = acc_y_ff;
            endcase
            if (mul_cnt_ff == MUL_LAST) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            x_in     = div4_trunc(acc_x_ff);
            y_in     = div4_trunc(acc_y_ff);
            state_in = S_PRE;
         end
         S_PRE: begin
            step_in = '0;
            ang_in  = '0;
            if (x_ff == '0 && y_ff == '0) begin
               state_in = S_ABS;
            end else begin
               state_in = S_ITER;
               // left half plane: quarter turn first
               if (x_ff < 0) begin
                  if (y_ff >= 0) begin
                     x_in   = y_ff;
                     y_in   = -x_ff;
                     ang_in = QTURN;
                  end else begin
                     x_in   = -y_ff;
                     y_in   = x_ff;
                     ang_in = -QTURN;
                  end
               end
            end
         end
         S_ITER: begin
            if (y_ff > 0) begin
               x_in   = x_ff + y_sh;
               y_in   = y_ff - x_sh;
               ang_in = ang_ff + atan_val;
            end else begin
               x_in   = x_ff - y_sh;
               y_in   = y_ff + x_sh;
               ang_in = ang_ff - atan_val;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            neg_in   = ang_ff[AW-1];
            mag_in   = ang_ff[AW-1] ? ang_neg[19:0] : ang_ff[19:0];
            state_in = S_SCALE;
         end
         S_SCALE: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               yaw_in       = neg_ff ? (16'sd0 - $signed(cd16)) : $signed(cd16);
               tb_out_in    = timebase_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_cnt_ff    <= '0;
         mul_cnt_ff   <= '0;
         step_ff      <= '0;
         timebase_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         mul_cnt_ff   <= mul_cnt_in;
         step_ff      <= step_in;
         timebase_ff  <= timebase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      q_ff      <= q_in;
      prod_ff   <= mul_a * mul_b;
      acc_y_ff  <= acc_y_in;
      acc_x_ff  <= acc_x_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      ang_ff    <= ang_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      yaw_ff    <= yaw_in;
      tb_out_ff <= tb_out_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_yaw_centideg     = yaw_ff;
   assign rsp_timebase_present = tb_out_ff;

endmodule
`default_nettype wire

>>> design/shtp_rotation_report_to_yaw.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shtp_rotation_report_to_yaw: sensor-hub rotation report to yaw angle
// Frames the packet byte stream and turns each accepted rotation report into
// a yaw angle in hundredths of a degree.
//
//   channel  direction  payload                                 handshake
//   req      in         rx_byte                                 valid/ready
//   rsp      out        yaw_centideg, timebase_present          valid/ready
//   csr      in         index, data (report id, report channel) valid/ready
//
// A byte that ends a report packet starts the solver: window reads, multiplier
// products, 16 CORDIC steps, load, setup, abs, scale and output until the
// result register loads; a zero vector skips the CORDIC steps, a foreign
// report id ends the run after the id read. req_ready is low meanwhile, and
// stays low while a new result waits behind one not yet taken on rsp. Reset
// is synchronous, active high.
// ----------------------------------------------------------------------------
module shtp_rotation_report_to_yaw (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_rx_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [15:0]                       rsp_yaw_centideg,
   output logic                                     rsp_timebase_present,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [shtp_ry_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                          csr_data
);

   logic [7:0]                      accepted_id_ff, accepted_id_in;
   logic [7:0]                      report_channel_ff, report_channel_in;
   logic                            byte_take;
   logic                            solver_busy;
   logic [shtp_ry_pkg::WIN_AW-1:0]  rd_addr;
   logic [7:0]                      rd_data;
   shtp_ry_pkg::event_type          evt;

   assign csr_ready = 1'b1;
   assign req_ready = !solver_busy;
   assign byte_take = req_valid && req_ready;

   // configuration register write decode
   always_comb begin
      accepted_id_in    = accepted_id_ff;
      report_channel_in = report_channel_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            shtp_ry_pkg::CSR_ACCEPTED_REPORT_ID: accepted_id_in    = csr_data;
            shtp_ry_pkg::CSR_REPORT_CHANNEL:     report_channel_in = csr_data;
            default:                             accepted_id_in    = accepted_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_id_ff    <= shtp_ry_pkg::ACCEPTED_REPORT_ID_RESET;
         report_channel_ff <= shtp_ry_pkg::REPORT_CHANNEL_RESET;
      end else begin
         accepted_id_ff    <= accepted_id_in;
         report_channel_ff <= report_channel_in;
      end
   end

   // packet framing
   shtp_ry_framer u_framer (
      .clock          (clock),
      .reset          (reset),
      .byte_take      (byte_take),
      .rx_byte        (req_rx_byte),
      .report_channel (report_channel_ff),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .evt            (evt)
   );

   // report check and yaw computation
   shtp_ry_solver u_solver (
      .clock                (clock),
      .reset                (reset),
      .evt                  (evt),
      .accepted_report_id   (accepted_id_ff),
      .rd_data              (rd_data),
      .rd_addr              (rd_addr),
      .busy                 (solver_busy),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_yaw_centideg     (rsp_yaw_centideg),
      .rsp_timebase_present (rsp_timebase_present)
   );

   // a report end only comes from a transfer on the request channel
   assert property (@(posedge clock) disable iff (reset)
      evt.valid |-> byte_take)
      else $error("report event without a request transfer");

   // input stalls once a report has ended
   assert property (@(posedge clock) disable iff (reset)
      evt.valid |=> !req_ready)
      else $error("request accepted while the solver runs");

   // a new result only appears after a solver run
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(solver_busy))
      else $error("result without a solver run");

   // result stays within half a turn
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_yaw_centideg <= 16'sd18000 && rsp_yaw_centideg >= -16'sd18000))
      else $error("yaw out of range");

endmodule
`default_nettype wire
